// ===== src/lfr_pkg.sv =====
package lfr_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned DATA_W         = 8 * MAX_DATA_BYTES;
  localparam int unsigned LANE_W         = $clog2(MAX_DATA_BYTES);

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  localparam logic [5:0] TARGET_ID_RST    = 6'd50;
  localparam logic [3:0] DATA_LENGTH_RST  = 4'd8;
  localparam logic [7:0] FRAME_TMO_RST    = 8'd50;
  localparam logic [7:0] BYTE_TMO_RST     = 8'd2;

  typedef enum logic [1:0] {
    CFG_TARGET_ID   = 2'd0,
    CFG_DATA_LENGTH = 2'd1,
    CFG_FRAME_TMO   = 2'd2,
    CFG_BYTE_TMO    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PARITY  = 2'd1,
    ST_CSUM    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  frame_id;
    logic [DATA_W-1:0] frame_data;
    logic [7:0]  rx_checksum;
    logic [15:0] good_frames;
    logic [15:0] parity_errors;
    logic [15:0] checksum_errors;
    logic [15:0] timeout_errors;
  } out_t;

  function automatic logic pid_parity_ok(input logic [7:0] pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return (pid[6] == p0) && (pid[7] == p1);
  endfunction

endpackage

// ===== src/lfr_core.sv =====
module lfr_core import lfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_idx_e   cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       item_go_i,
  input  in_t        item_i,
  output logic       res_valid_o,
  output out_t       res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PID  = 2'd1,
    PH_DATA = 2'd2,
    PH_CSUM = 2'd3
  } phase_e;

  logic [5:0] target_id_q;
  logic [3:0] data_length_q;
  logic [7:0] frame_tmo_q;
  logic [7:0] byte_tmo_q;

  phase_e            phase_q, phase_d;
  logic [3:0]        byte_index_q, byte_index_d;
  logic [7:0]        pid_q, pid_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        frame_timer_q, frame_timer_d;
  logic [7:0]        gap_timer_q, gap_timer_d;
  logic [15:0]       cnt_q [4];
  logic [15:0]       cnt_d [4];

  logic       emit;
  status_e    status;
  logic [7:0] csum_out;
  logic [3:0] eff_len;
  logic [3:0] index_inc;
  logic [8:0] sum_wide;
  logic [7:0] rx_b;

  assign rx_b = item_i.rx_byte;

  always_comb begin
    if (data_length_q == 4'd0) begin
      eff_len = 4'd1;
    end else if (data_length_q > 4'(MAX_DATA_BYTES)) begin
      eff_len = 4'(MAX_DATA_BYTES);
    end else begin
      eff_len = data_length_q;
    end
  end

  assign index_inc = byte_index_q + 4'd1;
  // end-around carry: fold the overflow back into the low byte
  assign sum_wide  = {1'b0, sum_q} + {1'b0, rx_b};

  always_comb begin
    phase_d       = phase_q;
    byte_index_d  = byte_index_q;
    pid_d         = pid_q;
    data_d        = data_q;
    sum_d         = sum_q;
    frame_timer_d = frame_timer_q;
    gap_timer_d   = gap_timer_q;
    emit          = 1'b0;
    status        = ST_OK;
    csum_out      = 8'h00;

    if (item_go_i) begin
      if (item_i.is_tick) begin
        if (phase_q != PH_IDLE) begin
          if (frame_timer_q != 8'hFF) begin
            frame_timer_d = frame_timer_q + 8'd1;
          end
          if (frame_timer_d > frame_tmo_q) begin
            emit   = 1'b1;
            status = ST_TIMEOUT;
          end else if (phase_q == PH_DATA || phase_q == PH_CSUM) begin
            if (gap_timer_q != 8'hFF) begin
              gap_timer_d = gap_timer_q + 8'd1;
            end
            if (gap_timer_d >= byte_tmo_q) begin
              emit   = 1'b1;
              status = ST_TIMEOUT;
            end
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (rx_b == SYNC_BYTE) begin
              phase_d       = PH_PID;
              pid_d         = 8'h00;
              data_d        = '0;
              frame_timer_d = 8'h00;
              gap_timer_d   = 8'h00;
            end
          end
          PH_PID: begin
            pid_d = rx_b;
            if (!pid_parity_ok(rx_b)) begin
              emit   = 1'b1;
              status = ST_PARITY;
            end else if (rx_b[5:0] != target_id_q) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d      = PH_DATA;
              byte_index_d = 4'd0;
              data_d       = '0;
              sum_d        = rx_b;
              gap_timer_d  = 8'h00;
            end
          end
          PH_DATA: begin
            gap_timer_d = 8'h00;
            for (int k = 0; k < MAX_DATA_BYTES; k++) begin
              if (byte_index_q[LANE_W-1:0] == LANE_W'(k)) begin
                data_d[8*k +: 8] = data_q[8*k +: 8] | rx_b;
              end
            end
            sum_d        = sum_wide[8] ? 8'(sum_wide - 9'h0FF) : sum_wide[7:0];
            byte_index_d = index_inc;
            if (index_inc >= eff_len) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            gap_timer_d = 8'h00;
            emit        = 1'b1;
            status      = (~sum_q == rx_b) ? ST_OK : ST_CSUM;
            csum_out    = rx_b;
          end
          default: ;
        endcase
      end
      if (emit) begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      cnt_d[s] = cnt_q[s];
    end
    if (emit) begin
      cnt_d[status] = cnt_q[status] + 16'd1;
    end
  end

  assign res_valid_o          = emit;
  assign res_o.status          = status;
  assign res_o.frame_id        = pid_d[5:0];
  assign res_o.frame_data      = (status == ST_PARITY) ? '0 : data_d;
  assign res_o.rx_checksum     = csum_out;
  assign res_o.good_frames     = cnt_d[ST_OK];
  assign res_o.parity_errors   = cnt_d[ST_PARITY];
  assign res_o.checksum_errors = cnt_d[ST_CSUM];
  assign res_o.timeout_errors  = cnt_d[ST_TIMEOUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q   <= TARGET_ID_RST;
      data_length_q <= DATA_LENGTH_RST;
      frame_tmo_q   <= FRAME_TMO_RST;
      byte_tmo_q    <= BYTE_TMO_RST;
      phase_q       <= PH_IDLE;
      byte_index_q  <= 4'd0;
      pid_q         <= 8'h00;
      data_q        <= '0;
      sum_q         <= 8'h00;
      frame_timer_q <= 8'h00;
      gap_timer_q   <= 8'h00;
      for (int s = 0; s < 4; s++) begin
        cnt_q[s] <= 16'd0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TARGET_ID:   target_id_q   <= cfg_data_i[5:0];
          CFG_DATA_LENGTH: data_length_q <= cfg_data_i[3:0];
          CFG_FRAME_TMO:   frame_tmo_q   <= cfg_data_i;
          CFG_BYTE_TMO:    byte_tmo_q    <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q       <= phase_d;
      byte_index_q  <= byte_index_d;
      pid_q         <= pid_d;
      data_q        <= data_d;
      sum_q         <= sum_d;
      frame_timer_q <= frame_timer_d;
      gap_timer_q   <= gap_timer_d;
      for (int s = 0; s < 4; s++) begin
        cnt_q[s] <= cnt_d[s];
      end
    end
  end

endmodule

// ===== src/lin_frame_receiver.sv =====
// Flow: a taken beat waits in the input register; once the result register is free or
// being drained, the core processes it and a frame result loads the result register.
// Throughput: one beat per cycle unless a stalled result blocks; the result and input
// registers let a new beat in while an earlier result waits to be taken.
// Reset: rst_ni clears frame state, statistics counters and both valid flags at once,
// and loads the configuration registers with their defaults.
module lin_frame_receiver import lfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  cfg_idx_e   cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  logic proc_go;
  logic item_go;
  logic in_take;
  logic res_valid;
  out_t res;

  // advance the held beat when the result register is free or being drained
  assign proc_go     = !out_valid_q || !out_stall_i;
  assign item_go     = in_valid_q && proc_go;
  assign in_stall_o  = in_valid_q && !proc_go;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  lfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_go_i   (item_go),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_go && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_go && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_parity_clears_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_PARITY) |->
      (out_data_o.frame_data == '0 && out_data_o.rx_checksum == 8'h00))
    else $error("parity error result carries payload");

  a_timeout_no_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_TIMEOUT) |-> out_data_o.rx_checksum == 8'h00)
    else $error("timeout result carries a checksum");

  a_beat_consumed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_go && !in_take) |=> !in_valid_q)
    else $error("input beat held after being processed");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule

// ===== bench/lin_frame_receiver_tb.sv =====
`timescale 1ns / 100ps

module lin_frame_receiver_tb;
  import lfr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_BEATS  = 500;

  typedef enum logic [1:0] {RX_IDLE, RX_PID, RX_DATA, RX_CSUM} rx_phase_e;
  typedef enum {FAULT_NONE, FAULT_PARITY, FAULT_CSUM} frame_fault_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  in_t        in_data_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  cfg_idx_e   cfg_index_i = CFG_TARGET_ID;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       in_stall_o;
  logic       out_valid_o;
  out_t       out_data_o;
  logic       cfg_ready_o;

  // Receiver state as seen by the bus
  rx_phase_e   rx_phase  = RX_IDLE;
  logic [3:0]  rx_index  = '0;
  logic [7:0]  rx_pid    = '0;
  logic [63:0] rx_data   = '0;
  logic [7:0]  rx_acc    = '0;
  logic [7:0]  frame_ms  = '0;
  logic [7:0]  gap_ms    = '0;
  logic [15:0] tally [4] = '{default: 16'd0};

  logic [5:0] cfg_target    = TARGET_ID_RST;
  logic [3:0] cfg_length    = DATA_LENGTH_RST;
  logic [7:0] cfg_frame_tmo = FRAME_TMO_RST;
  logic [7:0] cfg_byte_tmo  = BYTE_TMO_RST;

  out_t        frame_results_q[$];
  int unsigned live_beats   = 0;
  int unsigned mismatches   = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_cycles  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mode_left    = 0;
  int unsigned stall_tick   = 0;
  stall_mode_e stall_mode   = STALL_NONE;

  lin_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] pid_of(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Add with end-around carry
  function automatic logic [7:0] csum_add(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, acc} + {1'b0, b};
    if (t > 9'd255) t = t - 9'd255;
    return t[7:0];
  endfunction

  function automatic int unsigned used_length();
    if (cfg_length == 4'd0) return 1;
    if (cfg_length > MAX_DATA_BYTES) return MAX_DATA_BYTES;
    return cfg_length;
  endfunction

  function automatic void log_result(input status_e st, input logic [7:0] csum);
    out_t r;
    tally[st] = tally[st] + 16'd1;
    r.status          = st;
    r.frame_id        = rx_pid[5:0];
    r.frame_data      = (st == ST_PARITY) ? '0 : rx_data;
    r.rx_checksum     = csum;
    r.good_frames     = tally[ST_OK];
    r.parity_errors   = tally[ST_PARITY];
    r.checksum_errors = tally[ST_CSUM];
    r.timeout_errors  = tally[ST_TIMEOUT];
    frame_results_q.push_back(r);
    rx_phase = RX_IDLE;
  endfunction

  function automatic void track_beat(input in_t beat);
    logic [7:0] b;
    logic [7:0] want_csum;
    b = beat.rx_byte;
    if (rx_phase != RX_IDLE || (!beat.is_tick && b == SYNC_BYTE)) live_beats++;
    if (beat.is_tick) begin
      if (rx_phase == RX_IDLE) return;
      if (frame_ms != 8'hFF) frame_ms = frame_ms + 8'd1;
      if (frame_ms > cfg_frame_tmo) begin
        log_result(ST_TIMEOUT, 8'h00);
        return;
      end
      // the ID phase has no byte gap limit
      if (rx_phase == RX_DATA || rx_phase == RX_CSUM) begin
        if (gap_ms != 8'hFF) gap_ms = gap_ms + 8'd1;
        if (gap_ms >= cfg_byte_tmo) log_result(ST_TIMEOUT, 8'h00);
      end
      return;
    end
    case (rx_phase)
      RX_IDLE: begin
        if (b == SYNC_BYTE) begin
          rx_phase = RX_PID;
          rx_pid   = '0;
          rx_data  = '0;
          frame_ms = '0;
          gap_ms   = '0;
        end
      end
      RX_PID: begin
        rx_pid = b;
        if (b != pid_of(b[5:0])) begin
          log_result(ST_PARITY, 8'h00);
        end else if (b[5:0] != cfg_target) begin
          rx_phase = RX_IDLE;
        end else begin
          rx_phase = RX_DATA;
          rx_index = '0;
          rx_data  = '0;
          rx_acc   = b;
          gap_ms   = '0;
        end
      end
      RX_DATA: begin
        gap_ms   = '0;
        rx_data  = rx_data | (64'(b) << {rx_index[2:0], 3'b000});
        rx_acc   = csum_add(rx_acc, b);
        rx_index = rx_index + 4'd1;
        if (rx_index >= used_length()) rx_phase = RX_CSUM;
      end
      RX_CSUM: begin
        gap_ms    = '0;
        want_csum = ~rx_acc;
        log_result((b == want_csum) ? ST_OK : ST_CSUM, b);
      end
    endcase
  endfunction

  function automatic void store_reg(input cfg_idx_e idx, input logic [7:0] val);
    case (idx)
      CFG_TARGET_ID:   cfg_target    = val[5:0];
      CFG_DATA_LENGTH: cfg_length    = val[3:0];
      CFG_FRAME_TMO:   cfg_frame_tmo = val;
      CFG_BYTE_TMO:    cfg_byte_tmo  = val;
    endcase
  endfunction

  task automatic send_beat(input in_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    track_beat(beat);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(in_t'({1'b0, b}));
  endtask

  task automatic send_tick();
    logic [7:0] junk;
    junk = 8'($urandom);
    send_beat(in_t'({1'b1, junk}));
  endtask

  task automatic stray_ticks(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) repeat ($urandom_range(1, 3)) send_tick();
  endtask

  task automatic send_frame(input logic [5:0] id, input int unsigned n_data,
                            input frame_fault_e fault, input logic [63:0] payload,
                            input int unsigned tick_pct);
    logic [7:0] pid;
    logic [7:0] acc;
    logic [7:0] b;
    pid = pid_of(id);
    if (fault == FAULT_PARITY) pid = pid ^ {2'($urandom_range(1, 3)), 6'b0};
    send_byte(SYNC_BYTE);
    stray_ticks(tick_pct);
    send_byte(pid);
    if (fault == FAULT_PARITY) return;
    acc = pid;
    for (int i = 0; i < n_data; i++) begin
      b = payload[8 * (i % 8) +: 8];
      stray_ticks(tick_pct);
      send_byte(b);
      acc = csum_add(acc, b);
    end
    stray_ticks(tick_pct);
    b = ~acc;
    if (fault == FAULT_CSUM) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] tgt, input logic [7:0] len,
                           input logic [7:0] ftmo, input logic [7:0] btmo);
    cfg_idx_e   reg_order [4];
    logic [7:0] vals [4];
    reg_order = '{CFG_TARGET_ID, CFG_DATA_LENGTH, CFG_FRAME_TMO, CFG_BYTE_TMO};
    vals      = '{tgt, len, ftmo, btmo};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_order[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      store_reg(reg_order[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_idle_noise();
    send_byte(8'h00);
    send_tick();
    send_byte(8'hFF);
  endtask

  task automatic test_default_frame();
    send_frame(TARGET_ID_RST, 8, FAULT_NONE, 64'h00FF_55A5_FF00_01FF, 0);
  endtask

  task automatic test_frame_errors();
    configure(8'h00, 8'd1, 8'd255, 8'd1);
    send_frame(6'd0, 1, FAULT_NONE, 64'hFF, 0);
    send_frame(6'd0, 1, FAULT_CSUM, 64'h00, 0);
    send_frame(6'd0, 1, FAULT_PARITY, 64'h00, 0);
    // another ID: drop after the ID byte
    send_byte(SYNC_BYTE);
    send_byte(pid_of(6'd63));
    // byte gap in the data phase
    send_byte(SYNC_BYTE);
    send_byte(pid_of(6'd0));
    send_tick();
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_CYCLES;
    burst_left  = 1000;
    repeat (8) send_frame(6'($urandom), 0, FAULT_PARITY, '0, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned phase_no;
    int unsigned r;
    int unsigned n;
    int unsigned tick_pct;
    logic [63:0] payload;
    goal     = live_beats + RANDOM_BEATS;
    phase_no = 0;
    while (live_beats < goal) begin
      case (phase_no)
        0:       configure(8'hFF, 8'd15, 8'd255, 8'd255);
        1:       configure(8'h00, 8'd0, 8'd0, 8'd0);
        2:       configure(8'h3F, 8'd9, 8'd1, 8'd1);
        3:       configure(8'h00, 8'hF1, 8'd255, 8'd2);
        default: configure(8'($urandom_range(0, 63)),
                           ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 15))
                                                       : 8'($urandom_range(1, 8)),
                           $urandom_range(0, 1) ? 8'($urandom_range(0, 12))
                                                : 8'($urandom_range(13, 255)),
                           $urandom_range(0, 1) ? 8'($urandom_range(0, 4))
                                                : 8'($urandom_range(5, 255)));
      endcase
      tick_pct = $urandom_range(0, 30);
      repeat (14) begin
        r       = $urandom_range(0, 99);
        n       = used_length();
        payload = {$urandom, $urandom};
        if (r < 55) begin
          send_frame(cfg_target, n, FAULT_NONE, payload, tick_pct);
        end else if (r < 68) begin
          send_frame(cfg_target, n, FAULT_CSUM, payload, tick_pct);
        end else if (r < 76) begin
          send_frame(6'($urandom), n, FAULT_PARITY, payload, tick_pct);
        end else if (r < 84) begin
          send_frame(6'($urandom), n, FAULT_NONE, payload, tick_pct);
        end else if (r < 92) begin
          // one byte too many or too few
          send_frame(cfg_target, (n == 1 || $urandom_range(0, 1)) ? n + 1 : n - 1,
                     FAULT_NONE, payload, tick_pct);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) send_tick();
            else send_byte(8'($urandom));
          end
        end
      end
      phase_no++;
    end
  endtask

  function automatic void cmp_field(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (frame_results_q.size() == 0) begin
        $error("unexpected result beat: status %0d", out_data_o.status);
        mismatches++;
      end else begin
        want = frame_results_q.pop_front();
        cmp_field("status", want.status, out_data_o.status);
        cmp_field("frame_id", want.frame_id, out_data_o.frame_id);
        cmp_field("frame_data", want.frame_data, out_data_o.frame_data);
        cmp_field("rx_checksum", want.rx_checksum, out_data_o.rx_checksum);
        cmp_field("good_frames", want.good_frames, out_data_o.good_frames);
        cmp_field("parity_errors", want.parity_errors, out_data_o.parity_errors);
        cmp_field("checksum_errors", want.checksum_errors, out_data_o.checksum_errors);
        cmp_field("timeout_errors", want.timeout_errors, out_data_o.timeout_errors);
      end
    end
  end

  // Result side stall: a long hold on request, otherwise a changing pattern
  always @(posedge clk_i) begin
    stall_tick++;
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 25);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 99) < 70);
        STALL_PERIODIC: out_stall_i <= stall_tick[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_noise();
    test_default_frame();
    test_frame_errors();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lfr_pkg.sv
src/lfr_core.sv
src/lin_frame_receiver.sv
bench/lin_frame_receiver_tb.sv
